// ===== rtl/core/fixed_point_q16_mul_div_mad_defines.svh =====
// Assertion macros for the Q16 fixed-point multiply/divide/multiply-add unit.
// No dependencies; included by the modules that carry assertions.
`ifndef FIXED_POINT_Q16_MUL_DIV_MAD_DEFINES_SVH
`define FIXED_POINT_Q16_MUL_DIV_MAD_DEFINES_SVH

// Same-cycle implication, sampled on clk, muted in reset.
`define FQMD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, muted in reset.
`define FQMD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/fqmd_pkg.sv =====
// Shared constants and types for the Q16 fixed-point arithmetic unit.
// No dependencies.
package fqmd_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // operation codes
  localparam logic [1:0] KIND_MUL = 2'd0;
  localparam logic [1:0] KIND_DIV = 2'd1;
  localparam logic [1:0] KIND_MAD = 2'd2;
  localparam logic [1:0] KIND_RSV = 2'd3;  // reserved, runs as multiply

  localparam logic [31:0] RES_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] RES_MIN = 32'h8000_0000;

  // per-word control flags that ride down the pipe
  typedef struct packed {
    logic is_div;
    logic dz;
    logic qneg;
    logic a_neg;
    logic mul_ovf;
  } ctl_t;

endpackage

// ===== rtl/core/fqmd_div_stage.sv =====
// One restoring-division stage: produces one quotient bit per word.
// Depends on fqmd_pkg (ctl_t).
module fqmd_div_stage #(
  parameter int FRAC_BITS = fqmd_pkg::FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    up_valid,
  output logic                    up_ready,
  input  fqmd_pkg::ctl_t          up_ctl,
  input  logic [31:0]             up_rem,
  input  logic [32+FRAC_BITS-1:0] up_quo,
  input  logic [31:0]             up_dvs,
  input  logic [31:0]             up_mres,
  output logic                    dn_valid,
  input  logic                    dn_ready,
  output fqmd_pkg::ctl_t          dn_ctl,
  output logic [31:0]             dn_rem,
  output logic [32+FRAC_BITS-1:0] dn_quo,
  output logic [31:0]             dn_dvs,
  output logic [31:0]             dn_mres
);

  localparam int QW = 32 + FRAC_BITS;

  logic [32:0] sh;
  logic [33:0] diff;
  logic        take;
  logic [31:0] rem_next;
  logic [QW-1:0] quo_next;

  always_comb begin
    sh       = {up_rem, up_quo[QW-1]};
    diff     = {1'b0, sh} - {2'b00, up_dvs};
    take     = !diff[33];
    rem_next = take ? diff[31:0] : sh[31:0];
    quo_next = {up_quo[QW-2:0], take};
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dn_ctl  <= up_ctl;
      dn_rem  <= rem_next;
      dn_quo  <= quo_next;
      dn_dvs  <= up_dvs;
      dn_mres <= up_mres;
    end
  end

endmodule

// ===== rtl/core/fixed_point_q16_mul_div_mad.sv =====
// Top level of the signed Q16.16 multiply / divide / multiply-add unit.
// Depends on fqmd_pkg, fqmd_div_stage and fixed_point_q16_mul_div_mad_defines.svh.
//
//   channel | signals                          | direction
//   --------+----------------------------------+----------
//   in      | in_valid in_ready kind a b c     | to unit
//   out     | out_valid out_ready result       | from unit
//           | overflow div_by_zero             |
//
// One word enters per cycle unless a stall at the output backs up the pipe;
// the restoring divider produces one quotient bit per stage.
// Every operation travels the full pipe so words leave in order.
// rst (synchronous) clears the valid bits only; data registers are free.
// Each stage holds while its successor is full and stalled, so bubbles
// close up and no word is dropped or doubled.
`include "fixed_point_q16_mul_div_mad_defines.svh"

module fixed_point_q16_mul_div_mad #(
  parameter int FRAC_BITS = fqmd_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         kind,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  input  logic signed [31:0] c,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] result,
  output logic               overflow,
  output logic               div_by_zero
);

  localparam int QW = 32 + FRAC_BITS;  // quotient / |dividend| width
  localparam int NW = QW + 1;          // signed dividend width
  localparam int MW = 65;              // product plus scaled addend

  // ---------------------------------------------------------------
  // Stage 1: product, signed dividend, divisor magnitude
  // ---------------------------------------------------------------
  logic                 s1_v, r1;
  logic                 s1_div, s1_mad, s1_dz, s1_aneg, s1_bneg;
  logic signed [63:0]   s1_prod;
  logic [31:0]          s1_c;
  logic [NW-1:0]        s1_n;
  logic [31:0]          s1_bmag;

  logic [31:0]   bmag_in;
  logic [NW-1:0] n_base, hb_ext, n_in;
  logic          neg_in;

  always_comb begin
    bmag_in = b[31] ? (~b + 32'd1) : b;
    n_base  = {a[31], a, {FRAC_BITS{1'b0}}};
    hb_ext  = {{(NW-31){1'b0}}, bmag_in[31:1]};
    neg_in  = a[31] ^ b[31];
    n_in    = neg_in ? (n_base - hb_ext) : (n_base + hb_ext);
  end

  // ---------------------------------------------------------------
  // Stage 2: add scaled c, dividend magnitude and quotient sign
  // ---------------------------------------------------------------
  logic                 s2_v, r2;
  logic                 s2_div, s2_dz, s2_aneg, s2_qneg;
  logic [MW-1:0]        s2_sum;
  logic [QW-1:0]        s2_nmag;
  logic [31:0]          s2_bmag;

  logic [MW-1:0] prod_ext, c_sh;
  logic [NW-1:0] nabs;

  always_comb begin
    prod_ext = {s1_prod[63], s1_prod};
    c_sh     = {{(MW-32-FRAC_BITS){s1_c[31]}}, s1_c, {FRAC_BITS{1'b0}}};
    nabs     = s1_n[NW-1] ? (~s1_n + NW'(1)) : s1_n;
  end

  // ---------------------------------------------------------------
  // Stage 3: round-half-away bias, shift, multiply overflow
  // ---------------------------------------------------------------
  logic                 s3_v, r3;
  fqmd_pkg::ctl_t       s3_ctl;
  logic [QW-1:0]        s3_nmag;
  logic [31:0]          s3_bmag;
  logic [31:0]          s3_mres;

  logic [MW-1:0]           half, t_sum;
  logic [MW-FRAC_BITS-1:0] r_top;
  logic                    m_ovf;

  always_comb begin
    half  = MW'(1) << (FRAC_BITS - 1);
    t_sum = s2_sum[MW-1] ? (s2_sum - half) : (s2_sum + half);
    r_top = t_sum[MW-1:FRAC_BITS];  // arithmetic shift = floor
    m_ovf = !((&r_top[MW-FRAC_BITS-1:31]) || !(|r_top[MW-FRAC_BITS-1:31]));
  end

  // ---------------------------------------------------------------
  // Divider chain
  // ---------------------------------------------------------------
  logic                 ch_vld [0:QW];
  logic                 ch_rdy [0:QW];
  fqmd_pkg::ctl_t       ch_ctl [0:QW];
  logic [31:0]          ch_rem [0:QW];
  logic [QW-1:0]        ch_quo [0:QW];
  logic [31:0]          ch_dvs [0:QW];
  logic [31:0]          ch_mres[0:QW];

  assign ch_vld[0]  = s3_v;
  assign ch_ctl[0]  = s3_ctl;
  assign ch_rem[0]  = 32'd0;
  assign ch_quo[0]  = s3_nmag;
  assign ch_dvs[0]  = s3_bmag;
  assign ch_mres[0] = s3_mres;

  for (genvar k = 0; k < QW; k++) begin : g_div
    fqmd_div_stage #(.FRAC_BITS(FRAC_BITS)) u_stage (
      .clk      (clk),
      .rst      (rst),
      .up_valid (ch_vld[k]),
      .up_ready (ch_rdy[k]),
      .up_ctl   (ch_ctl[k]),
      .up_rem   (ch_rem[k]),
      .up_quo   (ch_quo[k]),
      .up_dvs   (ch_dvs[k]),
      .up_mres  (ch_mres[k]),
      .dn_valid (ch_vld[k+1]),
      .dn_ready (ch_rdy[k+1]),
      .dn_ctl   (ch_ctl[k+1]),
      .dn_rem   (ch_rem[k+1]),
      .dn_quo   (ch_quo[k+1]),
      .dn_dvs   (ch_dvs[k+1]),
      .dn_mres  (ch_mres[k+1])
    );
  end

  // ---------------------------------------------------------------
  // Output stage: sign the quotient, pick the result
  // ---------------------------------------------------------------
  fqmd_pkg::ctl_t fin_ctl;
  logic [QW:0]    qs;
  logic           q_ovf;
  logic [31:0]    res_next;
  logic           ovf_next, dz_next;

  always_comb begin
    fin_ctl = ch_ctl[QW];
    qs      = fin_ctl.qneg ? (~{1'b0, ch_quo[QW]} + (QW+1)'(1)) : {1'b0, ch_quo[QW]};
    q_ovf   = !((&qs[QW:31]) || !(|qs[QW:31]));
    dz_next = 1'b0;
    if (!fin_ctl.is_div) begin
      res_next = ch_mres[QW];
      ovf_next = fin_ctl.mul_ovf;
    end else if (fin_ctl.dz) begin
      res_next = fin_ctl.a_neg ? fqmd_pkg::RES_MIN : fqmd_pkg::RES_MAX;
      ovf_next = 1'b0;
      dz_next  = 1'b1;
    end else begin
      res_next = qs[31:0];
      ovf_next = q_ovf;
    end
  end

  // ready ripples back: a stage takes a word when empty or when draining
  assign ch_rdy[QW] = !out_valid || out_ready;
  assign r3         = !s3_v || ch_rdy[0];
  assign r2         = !s2_v || r3;
  assign r1         = !s1_v || r2;
  assign in_ready   = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      s3_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (r1)         s1_v      <= in_valid;
      if (r2)         s2_v      <= s1_v;
      if (r3)         s3_v      <= s2_v;
      if (ch_rdy[QW]) out_valid <= ch_vld[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && r1) begin
      s1_div  <= (kind == fqmd_pkg::KIND_DIV);
      s1_mad  <= (kind == fqmd_pkg::KIND_MAD);
      s1_dz   <= (b == 32'sd0);
      s1_aneg <= a[31];
      s1_bneg <= b[31];
      s1_prod <= a * b;
      s1_c    <= c;
      s1_n    <= n_in;
      s1_bmag <= bmag_in;
    end
    if (s1_v && r2) begin
      s2_div  <= s1_div;
      s2_dz   <= s1_dz;
      s2_aneg <= s1_aneg;
      s2_qneg <= s1_n[NW-1] ^ s1_bneg;
      s2_sum  <= s1_mad ? (prod_ext + c_sh) : prod_ext;
      s2_nmag <= nabs[QW-1:0];
      s2_bmag <= s1_bmag;
    end
    if (s2_v && r3) begin
      s3_ctl.is_div  <= s2_div;
      s3_ctl.dz      <= s2_dz;
      s3_ctl.qneg    <= s2_qneg;
      s3_ctl.a_neg   <= s2_aneg;
      s3_ctl.mul_ovf <= m_ovf;
      s3_nmag        <= s2_nmag;
      s3_bmag        <= s2_bmag;
      s3_mres        <= r_top[31:0];
    end
    if (ch_vld[QW] && ch_rdy[QW]) begin
      result      <= res_next;
      overflow    <= ovf_next;
      div_by_zero <= dz_next;
    end
  end

  // ---------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------
  // saturated words are 7FFFFFFF or 80000000: low bits all the inverse of the sign
  `FQMD_ASSERT_NOW(a_dz_no_ovf, out_valid && div_by_zero, !overflow, "dz word flags overflow")
  `FQMD_ASSERT_NOW(a_dz_sat, out_valid && div_by_zero, result[30:0] == {31{~result[31]}}, "dz unsat")
  `FQMD_ASSERT_NOW(a_empty_ready, !out_valid, in_ready, "input blocked with empty output")
  `FQMD_ASSERT_NEXT(a_out_fill, ch_vld[QW] && ch_rdy[QW], out_valid, "finished word lost")

endmodule

// ===== verif/fqmd_checker.sv =====
// Scoreboard for the Q16.16 multiply / divide / multiply-add unit.
// Depends on fqmd_pkg; watches both channels of the unit from outside.
module fqmd_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         kind,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  input  logic signed [31:0] c,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] result,
  input  logic               overflow,
  input  logic               div_by_zero,
  output int                 errors,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = fqmd_pkg::FRAC_BITS_DEF;

  typedef struct packed {
    logic [31:0] value;
    logic        ovf;
    logic        dz;
  } answer_t;

  answer_t answers_q[$];

  // half-biased floor shift of a wide signed value; >>> on signed is arithmetic
  function automatic logic signed [127:0] round_q(input logic signed [127:0] t);
    logic signed [127:0] half;
    half = 128'sd1 <<< (FB - 1);
    return (t >= 0) ? ((t + half) >>> FB) : ((t - half) >>> FB);
  endfunction

  function automatic answer_t compute_answer(input logic [1:0] k,
      input logic signed [31:0] x, input logic signed [31:0] y,
      input logic signed [31:0] z);
    logic signed [127:0] wa, wb, wc, r, n, hb;
    answer_t ans;
    wa = x; wb = y; wc = z;
    ans = '0;
    if (k == fqmd_pkg::KIND_DIV) begin
      if (y == 0) begin
        ans.value = (x >= 0) ? fqmd_pkg::RES_MAX : fqmd_pkg::RES_MIN;
        ans.dz = 1'b1;
        return ans;
      end
      n = wa <<< FB;
      hb = ((wb < 0) ? -wb : wb) / 2;
      r = (n + (((x < 0) != (y < 0)) ? -hb : hb)) / wb;  // truncates toward zero
    end else if (k == fqmd_pkg::KIND_MAD) begin
      r = round_q(wa * wb + (wc <<< FB));
    end else begin
      r = round_q(wa * wb);  // reserved kind behaves as multiply
    end
    ans.value = r[31:0];
    ans.ovf = (r > 128'sh7FFFFFFF) || (r < -128'sh80000000);
    return ans;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  assign pending = answers_q.size();

  initial errors = 0;

  always @(posedge clk) begin
    answer_t want;
    if (!rst) begin
      if (in_valid && in_ready) answers_q.push_back(compute_answer(kind, a, b, c));
      if (out_valid && out_ready) begin
        if (answers_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h", result));
        end else begin
          want = answers_q.pop_front();
          if (result !== want.value)
            report_mismatch($sformatf("result %h want %h", result, want.value));
          if (overflow !== want.ovf)
            report_mismatch($sformatf("overflow %b want %b", overflow, want.ovf));
          if (div_by_zero !== want.dz)
            report_mismatch($sformatf("div_by_zero %b want %b", div_by_zero, want.dz));
        end
      end
    end
  end
endmodule

// ===== verif/tb_fixed_point_q16_mul_div_mad.sv =====
// Stimulus and verdict for the Q16.16 multiply / divide / multiply-add unit.
// Depends on fqmd_pkg, fqmd_checker and the unit itself.
module tb_fixed_point_q16_mul_div_mad;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_WORDS = 930;
  localparam int LATENCY      = fqmd_pkg::FRAC_BITS_DEF + 36;
  localparam int STALL_LIMIT  = 20000;  // idle cycles; well above the longest gap

  logic clk = 1'b0, rst = 1'b1;
  logic in_valid = 1'b0, out_ready = 1'b0;
  logic [1:0] kind = fqmd_pkg::KIND_MUL;
  logic signed [31:0] a = '0, b = '0, c = '0;
  logic in_ready, out_valid, overflow, div_by_zero;
  logic signed [31:0] result;
  int errors, pending;
  int idle_cycles = 0;
  int stall_left = 0;
  bit sink_steady = 1'b0;

  always #5 clk = ~clk;

  fixed_point_q16_mul_div_mad u_top (.*);

  fqmd_checker u_chk (.*);

  // mostly short gaps, the odd long one
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // operands biased towards the awkward corners
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 3) - 1;
      3: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
      4: return 32'($signed($urandom_range(0, 511)) - 256) <<< 16;
      default: return $urandom;
    endcase
  endfunction

  // present one word and hold it until taken; valid drops only for a gap
  task automatic send_word(input logic [1:0] k, input logic [31:0] x,
                           input logic [31:0] y, input logic [31:0] z);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k; a <= x; b <= y; c <= z;
    do @(posedge clk); while (!in_ready);
  endtask

  // back-to-back burst: valid stays high between words
  task automatic send_burst(input int n);
    in_valid <= 1'b1;
    for (int i = 0; i < n; i++) begin
      kind <= 2'($urandom_range(0, 3));
      a <= pick_operand(); b <= pick_operand(); c <= pick_operand();
      do @(posedge clk); while (!in_ready);
    end
  endtask

  // receiver: stalls of random length, with stretches of steady ready
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (sink_steady || $urandom_range(0, 3) != 0) begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 199) == 0) sink_steady <= !sink_steady;
    end else begin
      out_ready  <= 1'b0;
      stall_left <= gap_len();
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[fixed_point_q16_mul_div_mad] ERROR");
      $finish;
    end
  end

  initial begin
    int sent;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    // directed: corners of every operation
    send_word(fqmd_pkg::KIND_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    send_word(fqmd_pkg::KIND_MUL, 32'h8000_0000, 32'h8000_0000, 0);
    send_word(fqmd_pkg::KIND_MUL, 32'h8000_0000, 32'h7FFF_FFFF, 0);
    send_word(fqmd_pkg::KIND_MUL, 32'h0001_8000, 32'hFFFF_8000, 0);
    send_word(fqmd_pkg::KIND_MUL, 32'h0000_0001, 32'h0000_8000, 0);
    send_word(fqmd_pkg::KIND_MUL, 32'hFFFF_FFFF, 32'h0000_8000, 0);
    send_word(fqmd_pkg::KIND_RSV, 32'h0002_0000, 32'h0003_0000, 32'h1234_5678);
    send_word(fqmd_pkg::KIND_DIV, 32'h0001_0000, 0, 0);  // divide by zero
    send_word(fqmd_pkg::KIND_DIV, 0, 0, 0);
    send_word(fqmd_pkg::KIND_DIV, 32'h8000_0000, 0, 0);
    send_word(fqmd_pkg::KIND_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 0);
    send_word(fqmd_pkg::KIND_DIV, 32'h7FFF_FFFF, 32'h0000_0001, 0);
    send_word(fqmd_pkg::KIND_DIV, 32'h0001_0000, 32'h0003_0000, 0);
    send_word(fqmd_pkg::KIND_DIV, 32'hFFFF_0000, 32'h0003_0000, 0);
    send_word(fqmd_pkg::KIND_DIV, 32'h0000_0001, 32'h8000_0000, 0);
    send_word(fqmd_pkg::KIND_DIV, 32'h8000_0000, 32'h8000_0000, 0);
    send_word(fqmd_pkg::KIND_MAD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_word(fqmd_pkg::KIND_MAD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_word(fqmd_pkg::KIND_MAD, 32'h0001_0000, 32'h0001_0000, 32'hFFFF_FFFF);
    send_word(fqmd_pkg::KIND_MAD, 32'hFFFF_8000, 32'h0000_0001, 0);
    // random: single words and back-to-back bursts
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      if ($urandom_range(0, 4) == 0) begin
        send_burst(12);
        sent += 12;
      end else begin
        send_word(2'($urandom_range(0, 3)), pick_operand(), pick_operand(), pick_operand());
        sent++;
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    if (errors == 0 && pending == 0) $display("[fixed_point_q16_mul_div_mad] OK");
    else $display("[fixed_point_q16_mul_div_mad] ERROR");
    $finish;
  end
endmodule
